// ----- hdl/rcfa_pkg.sv -----
package rcfa_pkg;

    // Field widths fixed by the request/result formats
    localparam int REQ_W  = 2;
    localparam int IDX_W  = 4;
    localparam int STAT_W = 3;
    localparam int REFS_W = 8;
    localparam int FREE_W = 5;

    // A 4-bit slot index reaches 16 slots at most
    localparam int ADDRESSABLE = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REF   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UNREF = 2'd2;
    localparam logic [REQ_W-1:0] REQ_PEEK  = 2'd3;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BAD_INDEX = 3'd2,
        ST_NOT_ALLOC = 3'd3,
        ST_SATURATED = 3'd4
    } t_status;

    // Controller -> datapath
    typedef struct packed {
        logic load_req;  // capture an incoming request
        logic exec;      // run the request, update counts, load result
        logic rc_start;  // capture pool size, start a free recount
        logic rc_step;   // scan one slot of the recount
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic rc_last;   // recount is on its last slot
    } t_dp_stat;

endpackage

// ----- hdl/rcfa_ctrl.sv -----
module rcfa_ctrl
    import rcfa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RECOUNT
    } t_state;

    t_state r_state;
    logic   r_res_valid;
    logic   res_free;

    // result register can take a new result this cycle
    assign res_free = !r_res_valid || i_res_ready;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_req_ready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_res_valid = r_res_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_req = i_req_valid && o_req_ready;
        o_cmd.rc_start = i_cfg_valid && o_cfg_ready;
        o_cmd.exec     = (r_state == S_EXEC) && res_free;
        o_cmd.rc_step  = (r_state == S_RECOUNT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            if (o_cmd.exec) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.rc_start) begin
                        r_state <= S_RECOUNT;
                    end else if (o_cmd.load_req) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (o_cmd.exec) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RECOUNT: begin
                    if (i_stat.rc_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/rcfa_datapath.sv -----
module rcfa_datapath
    import rcfa_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int REF_WIDTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [IDX_W-1:0]  i_slot_index,
    input  logic [FREE_W-1:0] i_pool_size,
    output logic [STAT_W-1:0] o_status,
    output logic [IDX_W-1:0]  o_granted_index,
    output logic [REFS_W-1:0] o_slot_refs,
    output logic [FREE_W-1:0] o_free_slots
);

    // only the addressable slots are ever touched
    localparam int ACT = (NUM_SLOTS < ADDRESSABLE) ? NUM_SLOTS : ADDRESSABLE;
    localparam int IW  = $clog2(ACT);
    localparam logic [FREE_W-1:0]    ACT_N   = FREE_W'(ACT);
    localparam logic [REF_WIDTH-1:0] REF_MAX = {REF_WIDTH{1'b1}};

    logic [REF_WIDTH-1:0] r_counts [ACT];
    logic [FREE_W-1:0]    r_free;
    logic [FREE_W-1:0]    r_pool;
    logic [REQ_W-1:0]     r_req;
    logic [IDX_W-1:0]     r_idx;
    logic [IW-1:0]        r_rc_idx;
    logic [FREE_W-1:0]    r_rc_acc;

    logic [STAT_W-1:0]    r_out_status;
    logic [IDX_W-1:0]     r_out_granted;
    logic [REFS_W-1:0]    r_out_refs;
    logic [FREE_W-1:0]    r_out_free;

    logic [FREE_W-1:0]    n_eff;
    logic [ACT-1:0]       zero_avail;
    logic                 found;
    logic [IW-1:0]        grant;
    logic [IW-1:0]        idx_sel;
    logic [REF_WIDTH-1:0] cur;

    // execution results
    t_status              n_status;
    logic [IDX_W-1:0]     n_granted;
    logic [REF_WIDTH-1:0] n_refs;
    logic [FREE_W-1:0]    n_free;
    logic                 wr_en;
    logic [IW-1:0]        wr_idx;
    logic [REF_WIDTH-1:0] wr_val;
    logic [15:0]          refs_ext;
    logic                 rc_hit;

    assign n_eff   = (r_pool < ACT_N) ? r_pool : ACT_N;
    assign idx_sel = r_idx[IW-1:0];
    assign cur     = r_counts[idx_sel];

    // free slots inside the active pool
    always_comb begin
        for (int i = 0; i < ACT; i++) begin
            zero_avail[i] = (r_counts[i] == '0) && (FREE_W'(i) < n_eff);
        end
    end

    // lowest free slot
    always_comb begin
        found = 1'b0;
        grant = '0;
        for (int i = ACT - 1; i >= 0; i--) begin
            if (zero_avail[i]) begin
                found = 1'b1;
                grant = IW'(i);
            end
        end
    end

    always_comb begin
        n_status  = ST_OK;
        n_granted = r_idx;
        n_refs    = '0;
        n_free    = r_free;
        wr_en     = 1'b0;
        wr_idx    = idx_sel;
        wr_val    = cur;
        if (r_req == REQ_ALLOC) begin
            n_granted = '0;
            if (r_free != '0 && found) begin
                n_granted = IDX_W'(grant);
                n_refs    = REF_WIDTH'(1);
                n_free    = r_free - 1'b1;
                wr_en     = 1'b1;
                wr_idx    = grant;
                wr_val    = REF_WIDTH'(1);
            end else begin
                n_status = ST_EMPTY;
            end
        end else if ({1'b0, r_idx} >= n_eff) begin
            n_status = ST_BAD_INDEX;
        end else if (r_req == REQ_PEEK) begin
            n_refs = cur;
        end else if (cur == '0) begin
            n_status = ST_NOT_ALLOC;
        end else if (r_req == REQ_REF) begin
            if (cur == REF_MAX) begin
                n_status = ST_SATURATED;
                n_refs   = cur;
            end else begin
                n_refs = cur + 1'b1;
                wr_en  = 1'b1;
                wr_val = cur + 1'b1;
            end
        end else begin
            n_refs = cur - 1'b1;
            wr_en  = 1'b1;
            wr_val = cur - 1'b1;
            if (cur == REF_WIDTH'(1)) begin
                n_free = r_free + 1'b1;
            end
        end
    end

    assign refs_ext = 16'(n_refs);
    assign rc_hit   = (r_counts[r_rc_idx] == '0) && (FREE_W'(r_rc_idx) < n_eff);
    assign o_stat.rc_last = (r_rc_idx == IW'(ACT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ACT; i++) begin
                r_counts[i] <= '0;
            end
            r_free   <= ACT_N;
            r_pool   <= FREE_W'(ADDRESSABLE);
            r_rc_idx <= '0;
            r_rc_acc <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_free <= n_free;
                if (wr_en) begin
                    r_counts[wr_idx] <= wr_val;
                end
            end
            if (i_cmd.rc_start) begin
                r_pool   <= i_pool_size;
                r_rc_idx <= '0;
                r_rc_acc <= '0;
            end else if (i_cmd.rc_step) begin
                r_rc_idx <= r_rc_idx + 1'b1;
                r_rc_acc <= r_rc_acc + FREE_W'(rc_hit);
                if (o_stat.rc_last) begin
                    r_free <= r_rc_acc + FREE_W'(rc_hit);
                end
            end
        end
    end

    // request capture and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req_type;
            r_idx <= i_slot_index;
        end
        if (i_cmd.exec) begin
            r_out_status  <= n_status;
            r_out_granted <= n_granted;
            r_out_refs    <= refs_ext[REFS_W-1:0];
            r_out_free    <= n_free;
        end
    end

    assign o_status        = r_out_status;
    assign o_granted_index = r_out_granted;
    assign o_slot_refs     = r_out_refs;
    assign o_free_slots    = r_out_free;

endmodule

// ----- hdl/refcounted_frame_allocator_core.sv -----
// Reference-counted frame slot allocator.
//
// Requests enter on the s_axis channel: tuser carries the request kind (alloc,
// add reference, drop reference, peek), tdata the slot index. Each request
// gives exactly one result on m_axis: tuser is the status code, tdata packs
// the granted/addressed slot, its count after the request and the number of
// free slots. Alloc grants the lowest free slot; pool empty means retry.
//
// Timing: one request at a time. An accepted request is captured, then run
// in the execute state, which loads the result register; no new request is
// taken until then. The limit is the single read-modify-write of the count
// table plus its free-slot search. The result sits in an output register, so
// a new request is taken while the previous result is still waiting. If the
// receiver stalls with a result held and another one finished, the block
// holds in its execute state, input ready low, until the held result is taken.
//
// The cfg channel writes pool_size. Each write starts a recount of the free
// slots, one per cycle across min(NUM_SLOTS,16) slots, with input ready low.
// Reset (synchronous, active low) clears all counts, sets pool_size to 16 and
// the free count to min(NUM_SLOTS,16); the block is ready the cycle after.
module refcounted_frame_allocator_core
    import rcfa_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int REF_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] slot_index, [7:4] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] granted_index, [11:4] slot_refs,
                                        // [16:12] free_slots, [23:17] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    // pool size register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic [STAT_W-1:0] res_status;
    logic [IDX_W-1:0]  res_granted;
    logic [REFS_W-1:0] res_refs;
    logic [FREE_W-1:0] res_free;

    rcfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    rcfa_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .REF_WIDTH (REF_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_req_type      (s_axis_tuser),
        .i_slot_index    (s_axis_tdata[IDX_W-1:0]),
        .i_pool_size     (i_cfg_data),
        .o_status        (res_status),
        .o_granted_index (res_granted),
        .o_slot_refs     (res_refs),
        .o_free_slots    (res_free)
    );

    assign m_axis_tdata = {7'd0, res_free, res_refs, res_granted};
    assign m_axis_tuser = res_status;

    // one request in flight: no request taken in the cycle after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is executing");

    // recount blocks requests
    a_recount_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !s_axis_tready && !o_cfg_ready)
        else $error("request channel open during recount");

    // pool empty result carries no slot and no count
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |->
            (m_axis_tdata[11:0] == 12'd0))
        else $error("pool empty result with nonzero slot fields");

    // free count never exceeds the addressable pool
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:12] <= 5'(ADDRESSABLE)))
        else $error("free slot count out of range");

endmodule
